// ===== hw/rtl/wsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wsp_pkg
// shared types and constants of the weighted stride picker
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

    // table geometry
    localparam int MAX_BACKENDS = 256;
    localparam int IDX_W        = 8;
    localparam int COUNT_W      = 9;
    localparam int WEIGHT_W     = 16;
    localparam int SEQ_W        = 32;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BACKEND_COUNT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQUENCE = 8'd1;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PICK = 1'b1;

    // backend count limits and reset value
    localparam logic [COUNT_W-1:0] MIN_COUNT    = 9'd2;
    localparam logic [COUNT_W-1:0] MAX_COUNT    = 9'd256;
    localparam logic [COUNT_W-1:0] BCOUNT_RESET = 9'd2;

    typedef logic [WEIGHT_W-1:0] t_weight;

    // stride arithmetic works modulo 2^16 - 1
    localparam t_weight       WEIGHT_FULL   = 16'hFFFF;
    localparam t_weight       GMOD_LAST     = 16'hFFFE;
    localparam logic [14:0]   STRIDE_OFFSET = 15'h7FFF;

endpackage

`default_nettype wire

// ===== hw/rtl/weighted_stride_picker_core.sv =====
// ----------------------------------------------------------------------------
// weighted_stride_picker_core
// static stride weighted round-robin picker over a 256 entry weight memory
// ----------------------------------------------------------------------------
// load: no result; the next transfer may follow at once
// pick: result registered once a try hits, held back while the output register stays
//   full; no new input transfer is taken until the pick is done
// each try is a multiply step and a check step, the next weight read overlapping the check
// config write: taken only at rest, then a divider pass (load, divide, finish) with no input transfer
// reset (synchronous, active low): counter 0, backend count 2, output empty, memory kept
`default_nettype none

module weighted_stride_picker_core
    import wsp_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,

    // input items
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire                   i_operation,
    input  wire  [IDX_W-1:0]      i_slot,
    input  wire  [WEIGHT_W-1:0]   i_weight_value,

    // result items
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic [IDX_W-1:0]      o_picked_index,

    // configuration writes
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_DLOAD = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DFIN  = 3'd5;

    logic [2:0]          r_state;

    // configuration registers
    logic [COUNT_W-1:0]  r_bcount;
    logic [COUNT_W-1:0]  w_n_eff;

    // sequence position: raw counter, counter mod n, (counter / n) mod 65535
    logic [SEQ_W-1:0]    r_seq;
    logic [IDX_W-1:0]    r_idx;
    t_weight             r_gmod;
    logic [SEQ_W-1:0]    n_seq;
    logic [IDX_W-1:0]    n_idx;
    t_weight             n_gmod;

    // weight memory, registered read
    t_weight             r_mem [0:MAX_BACKENDS-1];
    t_weight             r_rdata;
    logic                w_mem_we;
    logic                w_mem_re;
    logic [IDX_W-1:0]    w_rd_addr;
    t_weight             w_load_weight;

    // try datapath
    logic [31:0]         r_prod;
    logic [22:0]         r_off;
    logic [32:0]         w_sum;
    logic [17:0]         w_f1;
    logic [16:0]         w_f2;
    t_weight             w_test;
    logic                w_hit;
    logic                w_out_free;

    // divider
    logic [SEQ_W-1:0]    r_dvd;
    logic [COUNT_W-1:0]  r_rem;
    logic [4:0]          r_div_cnt;
    logic [COUNT_W:0]    w_rem_sh;
    logic [COUNT_W:0]    w_rem_diff;
    logic                w_qbit;
    logic [16:0]         w_q_s;
    t_weight             w_q_t;

    // output register
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_picked;

    logic                w_in_xfer;
    logic                w_cfg_xfer;

    // handshakes: config and items only while the sequencer rests, config wins a tie
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_cfg_xfer  = i_cfg_valid && o_cfg_ready;

    assign o_out_valid    = r_out_valid;
    assign o_picked_index = r_picked;
    assign w_out_free     = !r_out_valid || i_out_ready;

    // clamp of the backend count register
    always_comb begin
        if (r_bcount < MIN_COUNT) begin
            w_n_eff = MIN_COUNT;
        end else if (r_bcount > MAX_COUNT) begin
            w_n_eff = MAX_COUNT;
        end else begin
            w_n_eff = r_bcount;
        end
    end

    // next sequence position after one try; 32-bit wrap restarts at index 0
    always_comb begin
        n_seq  = r_seq + 32'd1;
        n_idx  = r_idx;
        n_gmod = r_gmod;
        if (r_seq == {SEQ_W{1'b1}}) begin
            n_idx  = '0;
            n_gmod = '0;
        end else if ({1'b0, r_idx} == (w_n_eff - 9'd1)) begin
            n_idx  = '0;
            n_gmod = (r_gmod == GMOD_LAST) ? '0 : (r_gmod + 16'd1);
        end else begin
            n_idx  = r_idx + 8'd1;
        end
    end

    // test = (w * gen + idx * 32767) mod 65535 by end-around folding
    always_comb begin
        w_sum  = {1'b0, r_prod} + {10'b0, r_off};
        w_f1   = {2'b0, w_sum[15:0]} + {1'b0, w_sum[32:16]};
        w_f2   = {1'b0, w_f1[15:0]} + {15'b0, w_f1[17:16]};
        if (w_f2 >= {1'b0, WEIGHT_FULL}) begin
            w_test = w_f2[15:0] - WEIGHT_FULL;
        end else begin
            w_test = w_f2[15:0];
        end
        w_hit = (r_rdata != '0) && (w_test >= (WEIGHT_FULL - r_rdata));
    end

    // memory port control: a rejected try fetches the next weight right away
    always_comb begin
        w_load_weight = (i_weight_value == '0) ? 16'd1 : i_weight_value;
        w_mem_we      = w_in_xfer && (i_operation == OP_LOAD);
        w_mem_re      = 1'b0;
        w_rd_addr     = r_idx;
        if (w_in_xfer && (i_operation == OP_PICK)) begin
            w_mem_re  = 1'b1;
        end else if ((r_state == S_CHK) && !w_hit) begin
            w_mem_re  = 1'b1;
            w_rd_addr = n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[i_slot] <= w_load_weight;
        end
        if (w_mem_re) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // restoring divider step, one quotient bit per cycle
    always_comb begin
        w_rem_sh   = {r_rem, r_dvd[SEQ_W-1]};
        w_rem_diff = w_rem_sh - {1'b0, w_n_eff};
        w_qbit     = (w_rem_sh >= {1'b0, w_n_eff});
        // quotient mod 65535
        w_q_s      = {1'b0, r_dvd[15:0]} + {1'b0, r_dvd[31:16]};
        w_q_t      = w_q_s[15:0] + {15'b0, w_q_s[16]};
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MUL: begin
                r_prod <= {16'b0, r_rdata} * {16'b0, r_gmod};
                r_off  <= {r_idx, 15'b0} - {15'b0, r_idx};
            end
            S_DLOAD: begin
                r_dvd     <= r_seq;
                r_rem     <= '0;
                r_div_cnt <= 5'd31;
            end
            S_DIV: begin
                r_dvd     <= {r_dvd[SEQ_W-2:0], w_qbit};
                r_rem     <= w_qbit ? w_rem_diff[COUNT_W-1:0] : w_rem_sh[COUNT_W-1:0];
                r_div_cnt <= r_div_cnt - 5'd1;
            end
            default: begin
            end
        endcase
        if ((r_state == S_CHK) && w_hit && w_out_free) begin
            r_picked <= r_idx;
        end
    end

    // control state, counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bcount    <= BCOUNT_RESET;
            r_seq       <= '0;
            r_idx       <= '0;
            r_gmod      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output valid: set by a winning check, cleared by the output transfer
            if ((r_state == S_CHK) && w_hit && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer && (i_operation == OP_PICK)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (!w_hit) begin
                        // try skipped, next weight already on its way
                        r_seq   <= n_seq;
                        r_idx   <= n_idx;
                        r_gmod  <= n_gmod;
                        r_state <= S_MUL;
                    end else if (w_out_free) begin
                        r_seq       <= n_seq;
                        r_idx       <= n_idx;
                        r_gmod      <= n_gmod;
                        r_state     <= S_IDLE;
                    end
                    // else hold until the output register frees up
                end
                S_DLOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_div_cnt == 5'd0) begin
                        r_state <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    r_idx   <= r_rem[IDX_W-1:0];
                    r_gmod  <= (w_q_t == WEIGHT_FULL) ? '0 : w_q_t;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // any config transfer rebuilds index and generation from the counter
            if (w_cfg_xfer) begin
                if (i_cfg_index == CFG_BACKEND_COUNT) begin
                    r_bcount <= i_cfg_data[COUNT_W-1:0];
                end else if (i_cfg_index == CFG_START_SEQUENCE) begin
                    r_seq <= i_cfg_data;
                end
                r_state <= S_DLOAD;
            end
        end
    end

    // index into the table stays below the backend count while at rest
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ({1'b0, r_idx} < w_n_eff))
        else $error("sequence index not below backend count");

    // generation residue never reaches the modulus
    a_gmod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gmod != WEIGHT_FULL)
        else $error("generation residue out of range");

    // a pick transfer always starts a try
    a_pick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (i_operation == OP_PICK)) |=> (r_state == S_MUL))
        else $error("pick transfer did not start a try");

    // a result only appears out of a successful check
    a_result_from_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_CHK))
        else $error("result raised outside of a check cycle");

endmodule

`default_nettype wire

// ===== dv/wsp_pick_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_pick_checker
// watches the input, result and register channels of the picker, works out
// the backend each pick should choose and compares it with what comes out
// ----------------------------------------------------------------------------

module wsp_pick_checker
    import wsp_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,

    input  wire                   i_in_valid,
    input  wire                   i_in_ready,
    input  wire                   i_operation,
    input  wire  [IDX_W-1:0]      i_slot,
    input  wire  [WEIGHT_W-1:0]   i_weight_value,

    input  wire                   i_out_valid,
    input  wire                   i_out_ready,
    input  wire  [IDX_W-1:0]      i_picked_index,

    input  wire                   i_cfg_valid,
    input  wire                   i_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,

    output int                    o_fail_count,
    output int                    o_pending
);

    t_weight            weights [MAX_BACKENDS];
    logic [SEQ_W-1:0]   seq_ctr;
    logic [COUNT_W-1:0] count_reg;
    logic [IDX_W-1:0]   picks_due [$];
    logic [IDX_W-1:0]   want_index;
    logic [IDX_W-1:0]   due_index;
    int                 fail_cnt = 0;
    int                 pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    // walk the sequence until a try lands on its weight's window
    function automatic logic [IDX_W-1:0] predict_pick();
        longint unsigned  n;
        longint unsigned  limit;
        longint unsigned  tries;
        longint unsigned  w;
        longint unsigned  gen;
        longint unsigned  test;
        logic [SEQ_W-1:0] s;
        logic [IDX_W-1:0] idx;
        n = 64'(count_reg);
        if (n < 64'(MIN_COUNT))
            n = 64'(MIN_COUNT);
        if (n > 64'(MAX_COUNT))
            n = 64'(MAX_COUNT);
        limit = 2 * 65536 * n + 2 * n;
        idx   = '0;
        for (tries = 0; tries < limit; tries++) begin
            s       = seq_ctr;
            seq_ctr = seq_ctr + 1'b1;
            idx     = IDX_W'(s % n);
            gen     = s / n;
            w       = 64'(weights[idx]);
            test    = (w * gen + idx * STRIDE_OFFSET) % WEIGHT_FULL;
            if (w != 0 && test >= WEIGHT_FULL - w)
                break;
        end
        return idx;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] picked_index %s: got %0d, expected %0d", $time, what, got, want);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_ctr   = '0;
            count_reg = BCOUNT_RESET;
            picks_due.delete();
            for (int k = 0; k < MAX_BACKENDS; k++)
                weights[k] = '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_BACKEND_COUNT)
                    count_reg = i_cfg_data[COUNT_W-1:0];
                else if (i_cfg_index == CFG_START_SEQUENCE)
                    seq_ctr = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_operation == OP_LOAD) begin
                    weights[i_slot] = (i_weight_value == '0) ? 16'd1 : i_weight_value;
                end else begin
                    due_index = predict_pick();
                    picks_due.insert(picks_due.size(), due_index);
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (picks_due.size() == 0) begin
                    report_mismatch("with no pick waiting", int'(i_picked_index), -1);
                end else begin
                    want_index = picks_due.pop_front();
                    if (i_picked_index !== want_index)
                        report_mismatch("differs", int'(i_picked_index), int'(want_index));
                end
            end
        end
        pending_cnt = picks_due.size();
    end

endmodule

// ===== dv/tb_weighted_stride_picker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_stride_picker_core
// drives weight loads, picks and register writes into the picker with random
// gaps on both channels; the checker beside the block predicts every pick
// ----------------------------------------------------------------------------

module tb_weighted_stride_picker_core
    import wsp_pkg::*;
();

    localparam int HOLD_CYCLES   = 240;    // long receiver hold-off
    localparam int SETTLE_CYCLES = 8;      // quiet time before a register write
    localparam int DRAIN_CYCLES  = 20;     // wait after the last result
    localparam int STALL_LIMIT   = 20000;  // cycles with no transfer at all
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 100;

    logic                  i_clk;
    logic                  rst_n;

    logic                  in_valid;
    logic                  in_ready;
    logic                  operation;
    logic [IDX_W-1:0]      slot;
    logic [WEIGHT_W-1:0]   weight_value;

    logic                  out_valid;
    logic                  out_ready;
    logic [IDX_W-1:0]      picked_index;

    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    fail_count;
    int                    pending_picks;

    // stimulus bookkeeping: which slots hold a weight, and which weight
    t_weight               shadow_w [MAX_BACKENDS];
    bit                    slot_written [MAX_BACKENDS];
    int                    eff_count;
    bit                    idle_on;
    bit                    hold_request;
    int                    n_sent;
    int                    n_picks;
    int                    n_cfg;
    int                    idle_cycles = 0;

    weighted_stride_picker_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_operation    (operation),
        .i_slot         (slot),
        .i_weight_value (weight_value),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_picked_index (picked_index),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    wsp_pick_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_operation    (operation),
        .i_slot         (slot),
        .i_weight_value (weight_value),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_picked_index (picked_index),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_picks)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // weights mostly in the upper three quarters so picks need few tries;
    // zero and one show up now and then
    function automatic t_weight random_weight();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return 16'd1;
            2:       return WEIGHT_FULL;
            3, 4, 5: return t_weight'($urandom_range(0, 65535));
            default: return t_weight'($urandom_range(16384, 65535));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] count_plan(input int ph);
        case (ph)
            0:       return 32'd3;
            1:       return 32'd256;
            2:       return 32'd2;
            3:       return 32'd511;   // above the table size, acts as 256
            4:       return $urandom_range(2, 256);
            5:       return 32'd300;
            6:       return 32'd1;     // below the minimum, acts as 2
            default: return $urandom_range(4, 64);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] start_plan(input int ph);
        case (ph)
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            3:       return 32'hFFFF_FF00;
            5:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // one input transfer; called and returning at a rising edge, valid is
    // left high so a following item goes out back to back
    task automatic send_item(input logic op, input logic [IDX_W-1:0] sl, input t_weight wv);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        slot         <= sl;
        weight_value <= wv;
        do @(negedge i_clk); while (!in_ready);
        @(posedge i_clk);
        n_sent++;
    endtask

    task automatic load_weight(input logic [IDX_W-1:0] sl, input t_weight wv);
        // keep a full weight on slot 0 or 1: a full weight always wins its
        // try, so every pick ends within one lap of the backends
        if (sl < 2 && wv != WEIGHT_FULL && shadow_w[sl ^ 8'd1] != WEIGHT_FULL)
            wv = WEIGHT_FULL;
        shadow_w[sl]     = wv;
        slot_written[sl] = 1'b1;
        send_item(OP_LOAD, sl, wv);
    endtask

    task automatic pick_item();
        // slot and weight are don't-care on a pick, fill them with noise
        send_item(OP_PICK, IDX_W'($urandom_range(0, 255)),
                  t_weight'($urandom_range(0, 65535)));
        n_picks++;
    endtask

    // register write only once the block has gone quiet
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_picks != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge i_clk); while (!cfg_ready);
        @(posedge i_clk);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    // every slot below the new count gets a weight before the count moves,
    // so a pick never reads an entry that was never written
    task automatic set_count(input logic [CFG_DATA_W-1:0] value);
        int n;
        n = int'(value[COUNT_W-1:0]);
        if (n < int'(MIN_COUNT))
            n = int'(MIN_COUNT);
        if (n > int'(MAX_COUNT))
            n = int'(MAX_COUNT);
        for (int s = 0; s < n; s++)
            if (!slot_written[s])
                load_weight(IDX_W'(s), random_weight());
        write_reg(CFG_BACKEND_COUNT, value);
        eff_count = n;
    endtask

    // receiver: random bursts of back-pressure plus one long hold-off
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        wait (rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready) ||
                       (cfg_valid && cfg_ready)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles with %0d picks outstanding",
                     idle_cycles, pending_picks);
            $display("weighted_stride_picker_core: mismatch");
            $finish;
        end
    end

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = OP_LOAD;
        slot         = '0;
        weight_value = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_BACKEND_COUNT;
        cfg_data     = '0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        eff_count    = int'(BCOUNT_RESET);
        n_sent       = 0;
        n_picks      = 0;
        n_cfg        = 0;
        for (int k = 0; k < MAX_BACKENDS; k++) begin
            shadow_w[k]     = '0;
            slot_written[k] = 1'b0;
        end

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: two backends out of reset, full and minimum weight
        load_weight(0, WEIGHT_FULL);
        load_weight(1, 16'd1);
        repeat (4) pick_item();
        // zero weight is stored as the smallest legal one
        load_weight(1, '0);
        repeat (2) pick_item();
        // top slot and alternating bit patterns
        load_weight(8'hFF, 16'h5555);
        load_weight(8'hAA, 16'hAAAA);
        load_weight(8'h55, 16'h7FFF);
        load_weight(1, 16'h8000);
        repeat (2) pick_item();
        // sequence counter wraps in the middle of a pick
        write_reg(CFG_START_SEQUENCE, 32'hFFFF_FFFE);
        repeat (3) pick_item();
        // count below range acts as the minimum
        set_count(32'd0);
        repeat (2) pick_item();
        // count above range acts as the table size, fills the whole table
        set_count(32'h0000_01FF);
        repeat (3) pick_item();

        // random phases, each with its own count and start position
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            idle_on = (ph != 3) && (ph < NUM_PHASES - 2);
            set_count(count_plan(ph));
            write_reg(CFG_START_SEQUENCE, start_plan(ph));
            if (ph == 1)
                hold_request = 1'b1;   // fill the block and stall its input
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 9) < 6)
                    pick_item();
                else if ($urandom_range(0, 4) != 0)
                    load_weight(IDX_W'($urandom_range(0, eff_count - 1)), random_weight());
                else
                    load_weight(IDX_W'($urandom_range(0, 255)), random_weight());
            end
        end

        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_picks != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d transfers (%0d picks) across %0d register writes",
                 n_sent, n_picks, n_cfg);
        $display("counts 0..511 raw, counter wrap, zero weights, one long output hold-off");
        if (fail_count == 0 && pending_picks == 0)
            $display("weighted_stride_picker_core: match");
        else
            $display("weighted_stride_picker_core: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/wsp_pkg.sv
hw/rtl/weighted_stride_picker_core.sv
dv/wsp_pick_checker.sv
dv/tb_weighted_stride_picker_core.sv
